// ===== src/hsfp_pkg.sv =====
// Shared constants, codes and control types of the scaled HMM forward pass.
// Used by the interfaces, the controller, the datapath and the top level.
package hsfp_pkg;

   localparam int MAX_STATES = 32;
   localparam int STATE_CAP  = (MAX_STATES < 32) ? MAX_STATES : 32;
   localparam int IDX_W      = $clog2(MAX_STATES);
   localparam int TADDR_W    = 2 * IDX_W;
   localparam int K_W        = 6;
   localparam int FIELD_W    = 5;
   localparam int VAL_W      = 32;
   localparam int U_W        = 48;
   localparam int SUM_W      = 56;
   localparam int ACC_W      = U_W + IDX_W;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;
   localparam int DIV_STEPS  = 32;

   localparam logic [1:0] FUNC_LOAD_TRANS = 2'd0;
   localparam logic [1:0] FUNC_LOAD_INIT  = 2'd1;
   localparam logic [1:0] FUNC_EMISSION   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_STATES     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMALIZE_FIRST = 1'd1;

   typedef struct packed {
      logic             trans_we;
      logic             init_we;
      logic             item_load;
      logic             dot_rd;
      logic             first_mul;
      logic             mul_hi;
      logic             mul_lo;
      logic             u_from_dot;
      logic             store;
      logic             div_init;
      logic             div_step;
      logic             out_load;
      logic             last;
      logic             norm;
      logic [IDX_W-1:0] row_idx;
      logic [IDX_W-1:0] item_from;
   } ctl_cmd_type;

   typedef struct packed {
      logic dot_busy;
      logic div_needed;
      logic out_free;
   } dp_status_type;

endpackage

// ===== src/hsfp_req_if.sv =====
// Request channel of the forward pass: handshake plus one input item.
// Depends on hsfp_pkg for field widths.
interface hsfp_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     func;
   logic [hsfp_pkg::FIELD_W-1:0]   from_state;
   logic [hsfp_pkg::FIELD_W-1:0]   to_state;
   logic [hsfp_pkg::VAL_W-1:0]     value;
   logic                           seq_start;

   modport source (output valid, func, from_state, to_state, value, seq_start,
                   input ready);
   modport sink (input valid, func, from_state, to_state, value, seq_start,
                 output ready);
endinterface

// ===== src/hsfp_rsp_if.sv =====
// Result channel of the forward pass: handshake plus one result item.
// Depends on hsfp_pkg for field widths.
interface hsfp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [hsfp_pkg::FIELD_W-1:0]   state_index;
   logic [hsfp_pkg::VAL_W-1:0]     alpha;
   logic [hsfp_pkg::SUM_W-1:0]     scale;
   logic                           scale_valid;
   logic                           zero_sum;
   logic                           last;

   modport source (output valid, state_index, alpha, scale, scale_valid, zero_sum, last,
                   input ready);
   modport sink (input valid, state_index, alpha, scale, scale_valid, zero_sum, last,
                 output ready);
endinterface

// ===== src/hsfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hsfp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== src/hsfp_ctl.sv =====
// Sequencing controller of the forward pass: decodes items, walks the dot
// product, the result loop and the divider. Depends on hsfp_pkg.
module hsfp_ctl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_func,
   input  logic [hsfp_pkg::FIELD_W-1:0]      req_from_state,
   input  logic [hsfp_pkg::FIELD_W-1:0]      req_to_state,
   input  logic                              req_seq_start,
   input  logic                              csr_we,
   input  logic [hsfp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hsfp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  hsfp_pkg::dp_status_type           status,
   output hsfp_pkg::ctl_cmd_type             cmd
);
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_INIT_RD  = 4'd1;
   localparam logic [3:0] ST_INIT_MUL = 4'd2;
   localparam logic [3:0] ST_DOT      = 4'd3;
   localparam logic [3:0] ST_DRAIN    = 4'd4;
   localparam logic [3:0] ST_MUL_HI   = 4'd5;
   localparam logic [3:0] ST_MUL_LO   = 4'd6;
   localparam logic [3:0] ST_U_CALC   = 4'd7;
   localparam logic [3:0] ST_STORE    = 4'd8;
   localparam logic [3:0] ST_OUT_RD   = 4'd9;
   localparam logic [3:0] ST_OUT_SET  = 4'd10;
   localparam logic [3:0] ST_DIV      = 4'd11;
   localparam logic [3:0] ST_OUT_PUSH = 4'd12;

   localparam int DIV_CNT_W = $clog2(hsfp_pkg::DIV_STEPS);

   logic [3:0]                       state_ff, state_in;
   logic [hsfp_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic [hsfp_pkg::IDX_W-1:0]       from_ff, from_in;
   logic [DIV_CNT_W-1:0]             div_cnt_ff, div_cnt_in;
   logic                             first_ff, first_in;
   logic [hsfp_pkg::K_W-1:0]         num_states_ff, num_states_in;
   logic                             norm_first_ff, norm_first_in;
   logic [hsfp_pkg::K_W-1:0]         k;
   logic [hsfp_pkg::K_W-1:0]         k_last;
   logic                             accept;
   logic                             idx_is_last;
   logic                             from_is_last;

   always_comb begin
      if (num_states_ff == '0) begin
         k = hsfp_pkg::K_W'(1);
      end else if (num_states_ff > hsfp_pkg::K_W'(hsfp_pkg::STATE_CAP)) begin
         k = hsfp_pkg::K_W'(hsfp_pkg::STATE_CAP);
      end else begin
         k = num_states_ff;
      end
   end

   assign k_last       = k - hsfp_pkg::K_W'(1);
   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign idx_is_last  = (hsfp_pkg::K_W'(idx_ff) == k_last);
   assign from_is_last = (hsfp_pkg::K_W'(from_ff) == k_last);

   always_comb begin
      num_states_in = num_states_ff;
      norm_first_in = norm_first_ff;
      if (csr_we) begin
         case (csr_index)
            hsfp_pkg::CSR_NUM_STATES: begin
               num_states_in = csr_wdata;
            end
            hsfp_pkg::CSR_NORMALIZE_FIRST: begin
               norm_first_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      from_in    = from_ff;
      div_cnt_in = div_cnt_ff;
      first_in   = first_ff;
      cmd        = '0;
      cmd.row_idx   = idx_ff;
      cmd.item_from = from_ff;
      cmd.norm      = !(first_ff && !norm_first_ff);
      cmd.last      = idx_is_last;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  hsfp_pkg::FUNC_LOAD_TRANS: begin
                     cmd.trans_we =
                        (32'(req_from_state) < hsfp_pkg::MAX_STATES) &&
                        (32'(req_to_state) < hsfp_pkg::MAX_STATES);
                  end
                  hsfp_pkg::FUNC_LOAD_INIT: begin
                     cmd.init_we = (32'(req_from_state) < hsfp_pkg::MAX_STATES);
                  end
                  hsfp_pkg::FUNC_EMISSION: begin
                     if (hsfp_pkg::K_W'(req_from_state) < k) begin
                        cmd.item_load = 1'b1;
                        from_in  = hsfp_pkg::IDX_W'(req_from_state);
                        first_in = req_seq_start;
                        idx_in   = '0;
                        state_in = req_seq_start ? ST_INIT_RD : ST_DOT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INIT_RD: begin
            state_in = ST_INIT_MUL;
         end
         ST_INIT_MUL: begin
            cmd.first_mul = 1'b1;
            state_in = ST_STORE;
         end
         ST_DOT: begin
            cmd.dot_rd = 1'b1;
            if (idx_is_last) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + hsfp_pkg::IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!status.dot_busy) begin
               state_in = ST_MUL_HI;
            end
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in = ST_U_CALC;
         end
         ST_U_CALC: begin
            cmd.u_from_dot = 1'b1;
            state_in = ST_STORE;
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            idx_in = '0;
            state_in = from_is_last ? ST_OUT_RD : ST_IDLE;
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_SET;
         end
         ST_OUT_SET: begin
            cmd.div_init = 1'b1;
            div_cnt_in = '0;
            state_in = status.div_needed ? ST_DIV : ST_OUT_PUSH;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == '1) begin
               state_in = ST_OUT_PUSH;
            end
         end
         ST_OUT_PUSH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (idx_is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + hsfp_pkg::IDX_W'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         from_ff       <= '0;
         div_cnt_ff    <= '0;
         first_ff      <= 1'b1;
         num_states_ff <= hsfp_pkg::K_W'(2);
         norm_first_ff <= 1'b1;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         from_ff       <= from_in;
         div_cnt_ff    <= div_cnt_in;
         first_ff      <= first_in;
         num_states_ff <= num_states_in;
         norm_first_ff <= norm_first_in;
      end
   end
endmodule

// ===== src/hsfp_dp.sv =====
// Datapath of the forward pass: stores, multiply-accumulate, row sum,
// restoring divider and result register. Depends on hsfp_pkg, hsfp_ram, hsfp_rsp_if.
module hsfp_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [hsfp_pkg::FIELD_W-1:0]  req_from_state,
   input  logic [hsfp_pkg::FIELD_W-1:0]  req_to_state,
   input  logic [hsfp_pkg::VAL_W-1:0]    req_value,
   input  hsfp_pkg::ctl_cmd_type         cmd,
   output hsfp_pkg::dp_status_type       status,
   hsfp_rsp_if.source                    rsp
);
   localparam int U_W   = hsfp_pkg::U_W;
   localparam int SUM_W = hsfp_pkg::SUM_W;
   localparam int VAL_W = hsfp_pkg::VAL_W;

   logic [VAL_W-1:0]              value_ff;
   logic [VAL_W-1:0]              trans_rd, init_rd, alpha_rd;
   logic [U_W-1:0]                unrm_rd;
   logic                          rd_v_ff, prod_v_ff;
   logic [U_W-1:0]                prod_ff;
   logic [hsfp_pkg::ACC_W-1:0]    acc_ff;
   logic [U_W-1:0]                dot_sat;
   logic [63:0]                   ph_ff, pl_ff;
   logic [64:0]                   u_sum;
   logic [U_W-1:0]                u_ff;
   logic [SUM_W-1:0]              row_sum_ff, sum_base;
   logic [SUM_W:0]                rem_ff;
   logic [SUM_W:0]                rem_shift;
   logic [SUM_W:0]                rem_diff;
   logic [VAL_W-1:0]              dvd_ff, q_ff;
   logic                          zero;
   logic                          sat;
   logic                          valid_ff;
   logic [hsfp_pkg::FIELD_W-1:0]  idx_out_ff;
   logic [VAL_W-1:0]              alpha_out_ff;
   logic [SUM_W-1:0]              scale_out_ff;
   logic                          scale_valid_ff, zero_out_ff, last_out_ff;

   hsfp_ram #(.WIDTH(VAL_W), .DEPTH(hsfp_pkg::MAX_STATES * hsfp_pkg::MAX_STATES)) u_trans (
      .clock(clock), .we(cmd.trans_we),
      .waddr({hsfp_pkg::IDX_W'(req_from_state), hsfp_pkg::IDX_W'(req_to_state)}),
      .wdata(req_value), .raddr({cmd.row_idx, cmd.item_from}), .rdata(trans_rd));

   hsfp_ram #(.WIDTH(VAL_W), .DEPTH(hsfp_pkg::MAX_STATES)) u_init (
      .clock(clock), .we(cmd.init_we), .waddr(hsfp_pkg::IDX_W'(req_from_state)),
      .wdata(req_value), .raddr(cmd.item_from), .rdata(init_rd));

   hsfp_ram #(.WIDTH(VAL_W), .DEPTH(hsfp_pkg::MAX_STATES)) u_alpha (
      .clock(clock), .we(cmd.out_load), .waddr(cmd.row_idx),
      .wdata(q_ff), .raddr(cmd.row_idx), .rdata(alpha_rd));

   hsfp_ram #(.WIDTH(U_W), .DEPTH(hsfp_pkg::MAX_STATES)) u_unrm (
      .clock(clock), .we(cmd.store), .waddr(cmd.item_from),
      .wdata(u_ff), .raddr(cmd.row_idx), .rdata(unrm_rd));

   assign dot_sat  = (|acc_ff[hsfp_pkg::ACC_W-1:U_W]) ? '1 : acc_ff[U_W-1:0];
   assign u_sum    = {1'b0, ph_ff} + {17'b0, pl_ff[63:16]};
   assign sum_base = (cmd.item_from == '0) ? '0 : row_sum_ff;
   assign zero     = cmd.norm && (row_sum_ff == '0);
   assign sat      = (row_sum_ff[SUM_W-1:32] == '0) &&
                     (unrm_rd >= {row_sum_ff[31:0], 16'b0});
   assign rem_shift = {rem_ff[SUM_W-1:0], dvd_ff[VAL_W-1]};
   assign rem_diff  = rem_shift - {1'b0, row_sum_ff};

   assign status.dot_busy   = rd_v_ff || prod_v_ff;
   assign status.div_needed = cmd.norm && !zero && !sat;
   assign status.out_free   = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         value_ff <= req_value;
      end
      if (rd_v_ff) begin
         prod_ff <= U_W'((64'(alpha_rd) * 64'(trans_rd)) >> 16);
      end
      if (cmd.item_load) begin
         acc_ff <= '0;
      end else if (prod_v_ff) begin
         acc_ff <= acc_ff + hsfp_pkg::ACC_W'(prod_ff);
      end
      if (cmd.mul_hi) begin
         ph_ff <= 64'(dot_sat) * 64'(value_ff[31:16]);
      end
      if (cmd.mul_lo) begin
         pl_ff <= 64'(dot_sat) * 64'(value_ff[15:0]);
      end
      if (cmd.first_mul) begin
         u_ff <= U_W'((64'(init_rd) * 64'(value_ff)) >> 16);
      end else if (cmd.u_from_dot) begin
         u_ff <= (|u_sum[64:U_W]) ? '1 : u_sum[U_W-1:0];
      end
      if (cmd.div_init) begin
         rem_ff <= (SUM_W + 1)'(unrm_rd[U_W-1:16]);
         dvd_ff <= {unrm_rd[15:0], 16'b0};
         if (!cmd.norm) begin
            q_ff <= (|unrm_rd[U_W-1:32]) ? '1 : unrm_rd[31:0];
         end else if (zero) begin
            q_ff <= '0;
         end else begin
            q_ff <= '1;
         end
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[VAL_W-2:0], 1'b0};
         if (!rem_diff[SUM_W]) begin
            rem_ff <= rem_diff;
            q_ff   <= {q_ff[VAL_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_shift;
            q_ff   <= {q_ff[VAL_W-2:0], 1'b0};
         end
      end
      if (cmd.out_load) begin
         idx_out_ff     <= hsfp_pkg::FIELD_W'(cmd.row_idx);
         alpha_out_ff   <= q_ff;
         scale_out_ff   <= cmd.norm ? row_sum_ff : '0;
         scale_valid_ff <= cmd.norm;
         zero_out_ff    <= zero;
         last_out_ff    <= cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff    <= 1'b0;
         prod_v_ff  <= 1'b0;
         row_sum_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         rd_v_ff   <= cmd.dot_rd;
         prod_v_ff <= rd_v_ff;
         if (cmd.store) begin
            row_sum_ff <= sum_base + SUM_W'(u_ff);
         end else if (cmd.out_load && cmd.last) begin
            row_sum_ff <= '0;
         end
         if (cmd.out_load) begin
            valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.state_index = idx_out_ff;
   assign rsp.alpha       = alpha_out_ff;
   assign rsp.scale       = scale_out_ff;
   assign rsp.scale_valid = scale_valid_ff;
   assign rsp.zero_sum    = zero_out_ff;
   assign rsp.last        = last_out_ff;
endmodule

// ===== src/hmm_scaled_forward_pass.sv =====
// Top level of the scaled hidden Markov model forward pass.
// Depends on hsfp_pkg, hsfp_req_if, hsfp_rsp_if, hsfp_ctl and hsfp_dp.
//
// The block takes one request beat at a time. Load beats (transition entry
// or initial probability) leave it idle and ready for the next beat. An
// emission beat for state s on the first step of a sequence goes through
// the initial-probability multiply; on later steps, where K is the number of
// states in use, the dot product of the previous alpha row with transition
// column s runs one multiply-accumulate per cycle through the transition and
// alpha memories, followed by a drain of the read and product registers and
// the emission multiply. The emission of the last state (K-1) then produces
// K result beats; each one also runs through the bit-serial divider when the
// alpha is normalized by a nonzero row sum that does not saturate it, and
// waits on rsp.ready while the result register holds a beat. No request beat
// is taken while a step is being computed or its results delivered.
// Configuration writes (register 0 num_states, register 1 normalize_first)
// take effect on the next cycle and must only be issued while the block is
// idle. Memories come up with undefined contents and must be loaded before
// they are used; there is no clearing pass after reset.
module hmm_scaled_forward_pass (
   input  logic                              clock,
   input  logic                              reset,
   hsfp_req_if.sink                          req,
   hsfp_rsp_if.source                        rsp,
   input  logic                              csr_we,
   input  logic [hsfp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hsfp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   hsfp_pkg::ctl_cmd_type    cmd;
   hsfp_pkg::dp_status_type  status;

   // The controller decides when a request beat is taken and sequences
   // every multi-cycle operation through command bits.
   hsfp_ctl u_ctl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req.valid),
      .req_ready      (req.ready),
      .req_func       (req.func),
      .req_from_state (req.from_state),
      .req_to_state   (req.to_state),
      .req_seq_start  (req.seq_start),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .status         (status),
      .cmd            (cmd)
   );

   // The datapath holds the memories, arithmetic and the result register.
   hsfp_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_from_state (req.from_state),
      .req_to_state   (req.to_state),
      .req_value      (req.value),
      .cmd            (cmd),
      .status         (status),
      .rsp            (rsp)
   );
endmodule

// ===== bench/hmm_scaled_forward_pass_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the scaled HMM forward pass: loads, emission steps and result beats.
// Depends on hsfp_pkg, hsfp_req_if, hsfp_rsp_if and the hmm_scaled_forward_pass top level.
module hmm_scaled_forward_pass_test;

   // Function code that the block does not know.
   localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

   // One expected or observed result beat.
   typedef struct packed {
      logic [hsfp_pkg::FIELD_W-1:0] state_index;
      logic [hsfp_pkg::VAL_W-1:0]   alpha;
      logic [hsfp_pkg::SUM_W-1:0]   scale;
      logic                         scale_valid;
      logic                         zero_sum;
      logic                         last;
   } alpha_beat_type;

   // Forward-pass predictor with its own copy of the stores and registers. Every
   // accepted request beat goes through absorb_item; every result beat through
   // check_alpha_beat, which compares it with the oldest predicted beat.
   class scoreboard_type;
      logic [hsfp_pkg::VAL_W-1:0] trans_mem [hsfp_pkg::MAX_STATES][hsfp_pkg::MAX_STATES];
      logic [hsfp_pkg::VAL_W-1:0] init_mem [hsfp_pkg::MAX_STATES];
      logic [hsfp_pkg::VAL_W-1:0] alpha_mem [hsfp_pkg::MAX_STATES];
      logic [hsfp_pkg::U_W-1:0]   raw_mem [hsfp_pkg::MAX_STATES];
      logic [hsfp_pkg::SUM_W-1:0] row_total;
      bit                         first_mode;
      logic [5:0]                 num_states;
      bit                         normalize_first;
      alpha_beat_type             pending_alphas[$];
      // Highest state count for which a whole alpha row has been produced.
      int                         alpha_span;
      int                         mismatches;
      int                         beats_checked;
      int                         steps_done;

      function new();
         row_total = '0;
         first_mode = 1;
         num_states = 6'd2;
         normalize_first = 1;
         alpha_span = 0;
         mismatches = 0;
         beats_checked = 0;
         steps_done = 0;
      endfunction

      function int states_in_use();
         int k;
         k = num_states;
         if (k < 1) k = 1;
         if (k > hsfp_pkg::STATE_CAP) k = hsfp_pkg::STATE_CAP;
         return k;
      endfunction

      task report(input string what);
         mismatches++;
         $display("MISMATCH at %0t: %s", $realtime, what);
      endtask

      function void absorb_item(logic [1:0] func, logic [4:0] from_s, logic [4:0] to_s,
                                logic [31:0] value, logic seq_first);
         int                         k;
         logic [63:0]                dot;
         logic [79:0]                wide;
         logic [hsfp_pkg::U_W-1:0]   u;
         logic [63:0]                a;
         bit                         norm;
         bit                         zero;
         alpha_beat_type             b;
         k = states_in_use();
         if (func == hsfp_pkg::FUNC_LOAD_TRANS) begin
            trans_mem[from_s][to_s] = value;
            return;
         end
         if (func == hsfp_pkg::FUNC_LOAD_INIT) begin
            init_mem[from_s] = value;
            return;
         end
         if (func != hsfp_pkg::FUNC_EMISSION || from_s >= k) return;

         if (from_s == 0) row_total = '0;
         first_mode = seq_first;
         if (seq_first) begin
            wide = (80'(init_mem[from_s]) * 80'(value)) >> 16;
            u = wide[hsfp_pkg::U_W-1:0];
         end else begin
            dot = '0;
            for (int i = 0; i < k; i++)
               dot += (64'(alpha_mem[i]) * 64'(trans_mem[i][from_s])) >> 16;
            if (dot > 64'hFFFF_FFFF_FFFF) dot = 64'hFFFF_FFFF_FFFF;
            wide = (80'(dot) * 80'(value)) >> 16;
            u = (wide > 80'hFFFF_FFFF_FFFF) ? {hsfp_pkg::U_W{1'b1}}
                                            : wide[hsfp_pkg::U_W-1:0];
         end
         raw_mem[from_s] = u;
         row_total = row_total + hsfp_pkg::SUM_W'(u);
         if (from_s != k - 1) return;

         // Last state of the step: the whole row comes out.
         norm = !(first_mode && !normalize_first);
         zero = norm && (row_total == '0);
         for (int i = 0; i < k; i++) begin
            if (!norm) a = 64'(raw_mem[i]);
            else if (zero) a = '0;
            else a = {raw_mem[i], 16'h0} / 64'(row_total);
            if (a > 64'hFFFF_FFFF) a = 64'hFFFF_FFFF;
            alpha_mem[i] = a[31:0];
            b.state_index = i[4:0];
            b.alpha = a[31:0];
            b.scale = norm ? row_total : '0;
            b.scale_valid = norm;
            b.zero_sum = zero;
            b.last = (i == k - 1);
            pending_alphas.push_back(b);
         end
         row_total = '0;
         steps_done++;
         if (k > alpha_span) alpha_span = k;
      endfunction

      task check_alpha_beat(input alpha_beat_type got);
         alpha_beat_type want;
         beats_checked++;
         if (pending_alphas.size() == 0) begin
            report($sformatf("unexpected result beat for state %0d", got.state_index));
            return;
         end
         want = pending_alphas.pop_front();
         if (got.state_index !== want.state_index)
            report($sformatf("state_index %0d, wanted %0d", got.state_index, want.state_index));
         if (got.alpha !== want.alpha)
            report($sformatf("state %0d alpha %h, wanted %h", want.state_index,
                             got.alpha, want.alpha));
         if (got.scale !== want.scale)
            report($sformatf("state %0d scale %h, wanted %h", want.state_index,
                             got.scale, want.scale));
         if (got.scale_valid !== want.scale_valid)
            report($sformatf("state %0d scale_valid %b, wanted %b", want.state_index,
                             got.scale_valid, want.scale_valid));
         if (got.zero_sum !== want.zero_sum)
            report($sformatf("state %0d zero_sum %b, wanted %b", want.state_index,
                             got.zero_sum, want.zero_sum));
         if (got.last !== want.last)
            report($sformatf("state %0d last %b, wanted %b", want.state_index,
                             got.last, want.last));
      endtask
   endclass

   // Emissions of the random part; loads and ignored beats bring the total
   // number of request beats to roughly 470.
   localparam int RANDOM_ITEMS = 300;
   localparam int STALL_LIMIT  = 5000;
   // Enough quiet cycles for a dot product over 32 states to drain before a write.
   localparam int DRAIN_CYCLES = 80;
   // Largest state count whose transition matrix is loaded; above it every step
   // is a first step, which keeps the number of load beats small.
   localparam int TRANS_SPAN   = 8;

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [hsfp_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [hsfp_pkg::CSR_DATA_W-1:0] csr_wdata;

   hsfp_req_if req_ch ();
   hsfp_rsp_if rsp_ch ();

   hmm_scaled_forward_pass dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch.sink),
      .rsp       (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   scoreboard_type sb = new();

   // Idle percentages for the two sides; the stimulus moves them through three settings.
   int send_idle_pct = 36;
   int recv_idle_pct = 67;
   int random_sent   = 0;
   int items_sent    = 0;
   int quiet_cycles  = 0;

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // All inputs start at known values before the first edge.
   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = hsfp_pkg::CSR_NUM_STATES;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.func = hsfp_pkg::FUNC_LOAD_TRANS;
      req_ch.from_state = '0;
      req_ch.to_state = '0;
      req_ch.value = '0;
      req_ch.seq_start = 1'b0;
      rsp_ch.ready = 1'b0;
   end

   // The receiver stalls at random; it is held off until reset is over.
   always @(posedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitor: every accepted beat on either channel goes to the scoreboard. The
   // values read here are the ones that stood before this edge, so the order of
   // events inside the time step does not matter.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.absorb_item(req_ch.func, req_ch.from_state, req_ch.to_state,
                           req_ch.value, req_ch.seq_start);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_alpha_beat('{rsp_ch.state_index, rsp_ch.alpha, rsp_ch.scale,
                                  rsp_ch.scale_valid, rsp_ch.zero_sum, rsp_ch.last});
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Presents one request beat and returns at the edge where it was taken. The
   // valid is only lowered when the sender decides to idle, so a back-to-back
   // beat never sees valid dropped and raised in the same time step.
   task send_item(input logic [1:0] func, input logic [4:0] from_s, input logic [4:0] to_s,
                  input logic [31:0] value, input logic seq_first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func <= func;
      req_ch.from_state <= from_s;
      req_ch.to_state <= to_s;
      req_ch.value <= value;
      req_ch.seq_start <= seq_first;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // Waits until every predicted beat is out and the block has had time to finish
   // any emission that produces no result.
   task drain;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_alphas.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes both registers while the block is quiet.
   task set_registers(input logic [5:0] states, input logic norm_first);
      drain();
      csr_we <= 1'b1;
      csr_index <= hsfp_pkg::CSR_NUM_STATES;
      csr_wdata <= states;
      @(posedge clock);
      sb.num_states = states;
      csr_index <= hsfp_pkg::CSR_NORMALIZE_FIRST;
      csr_wdata <= hsfp_pkg::CSR_DATA_W'(norm_first);
      @(posedge clock);
      sb.normalize_first = norm_first;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Values lean toward proper probabilities but also hit zero, one and the top code.
   function logic [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h0001_0000;
         3, 4: return $urandom;
         default: return $urandom_range(32'h0001_0000);
      endcase
   endfunction

   // Transition entries that were never written for the current state count are
   // loaded before any dot product can read them; a few others are rewritten.
   bit trans_loaded [hsfp_pkg::MAX_STATES][hsfp_pkg::MAX_STATES];

   task load_tables(input int k);
      if (k <= TRANS_SPAN)
         for (int i = 0; i < k; i++)
            for (int j = 0; j < k; j++)
               if (!trans_loaded[i][j] || $urandom_range(15) == 0) begin
                  send_item(hsfp_pkg::FUNC_LOAD_TRANS, i[4:0], j[4:0], pick_value(),
                            1'($urandom_range(1)));
                  trans_loaded[i][j] = 1;
               end
      for (int i = 0; i < k; i++)
         send_item(hsfp_pkg::FUNC_LOAD_INIT, i[4:0], 5'($urandom), pick_value(),
                   1'($urandom_range(1)));
   endtask

   // One time step of emissions in state order, with noise mixed in: an unknown
   // func, an emission beyond the states in use, a repeated state, an aborted step.
   // A later step is only chosen once an alpha row covers every state in use and
   // the transition matrix for that many states has been loaded.
   task run_step(input int k);
      bit first;
      bit mixed;
      bit zeros;
      int stop_at;
      first = (sb.alpha_span < k) || (k > TRANS_SPAN) || ($urandom_range(2) == 0);
      mixed = !first && ($urandom_range(9) == 0);
      zeros = ($urandom_range(11) == 0);
      stop_at = (k > 1 && $urandom_range(9) == 0) ? int'($urandom_range(k - 2)) : k - 1;
      for (int s = 0; s <= stop_at; s++) begin
         if ($urandom_range(9) == 0) begin
            case ($urandom_range(2))
               0: send_item(FUNC_UNKNOWN, 5'($urandom), 5'($urandom), $urandom,
                            1'($urandom_range(1)));
               1: if (k < 32)
                     send_item(hsfp_pkg::FUNC_EMISSION, 5'($urandom_range(31, k)),
                               5'($urandom), $urandom, 1'($urandom_range(1)));
               default: if (s > 0) begin
                     send_item(hsfp_pkg::FUNC_EMISSION, 5'(s - 1), 5'($urandom),
                               zeros ? 32'h0 : pick_value(), first);
                     random_sent++;
                  end
            endcase
         end
         send_item(hsfp_pkg::FUNC_EMISSION, s[4:0], 5'($urandom),
                   zeros ? 32'h0 : pick_value(),
                   mixed ? 1'($urandom_range(1)) : first);
         random_sent++;
         if (random_sent >= 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (random_sent >= RANDOM_ITEMS / 3) begin
            send_idle_pct = 67;
            recv_idle_pct = 36;
         end
      end
   endtask

   // Register settings walked by the random part, extremes included (0 and 63
   // clamp to one state and to the full 32).
   logic [5:0] state_plan [8] = '{6'd1, 6'd32, 6'd0, 6'd5, 6'd63, 6'd3, 6'd17, 6'd2};
   bit         norm_plan  [8] = '{0, 1, 0, 1, 1, 0, 1, 0};

   initial begin
      int k;
      int phase_end;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset settings (two states, first step normalized).
      send_item(hsfp_pkg::FUNC_LOAD_TRANS, 5'd0, 5'd0, 32'hFFFF_FFFF, 1'b0);
      send_item(hsfp_pkg::FUNC_LOAD_TRANS, 5'd0, 5'd1, 32'h0, 1'b1);
      send_item(hsfp_pkg::FUNC_LOAD_TRANS, 5'd1, 5'd0, 32'h0001_0000, 1'b0);
      send_item(hsfp_pkg::FUNC_LOAD_TRANS, 5'd1, 5'd1, 32'h0000_0001, 1'b1);
      trans_loaded[0][0] = 1;
      trans_loaded[0][1] = 1;
      trans_loaded[1][0] = 1;
      trans_loaded[1][1] = 1;
      send_item(hsfp_pkg::FUNC_LOAD_INIT, 5'd0, 5'd31, 32'hFFFF_FFFF, 1'b0);
      send_item(hsfp_pkg::FUNC_LOAD_INIT, 5'd1, 5'd0, 32'h0000_8000, 1'b0);
      // First step with emission values at the top code.
      send_item(hsfp_pkg::FUNC_EMISSION, 5'd0, 5'd0, 32'hFFFF_FFFF, 1'b1);
      send_item(hsfp_pkg::FUNC_EMISSION, 5'd1, 5'd0, 32'hFFFF_FFFF, 1'b1);
      // A later step whose row sums to zero.
      send_item(hsfp_pkg::FUNC_EMISSION, 5'd0, 5'd0, 32'h0, 1'b0);
      send_item(hsfp_pkg::FUNC_EMISSION, 5'd1, 5'd0, 32'h0, 1'b0);
      // Ignored beats: unknown func and a state beyond the two in use.
      send_item(FUNC_UNKNOWN, 5'd1, 5'd1, 32'hFFFF_FFFF, 1'b1);
      send_item(hsfp_pkg::FUNC_EMISSION, 5'd31, 5'd31, 32'h1234_5678, 1'b1);
      // Fresh first step with a repeated state, then an ordinary later step.
      send_item(hsfp_pkg::FUNC_EMISSION, 5'd0, 5'd0, 32'h0000_4000, 1'b1);
      send_item(hsfp_pkg::FUNC_EMISSION, 5'd0, 5'd0, 32'h0001_0000, 1'b1);
      send_item(hsfp_pkg::FUNC_EMISSION, 5'd1, 5'd0, 32'h0000_C000, 1'b1);
      send_item(hsfp_pkg::FUNC_EMISSION, 5'd0, 5'd0, 32'h0000_8000, 1'b0);
      send_item(hsfp_pkg::FUNC_EMISSION, 5'd1, 5'd0, 32'h0002_0000, 1'b0);
      // Raw first step with normalization of the first step switched off.
      set_registers(6'd2, 1'b0);
      send_item(hsfp_pkg::FUNC_EMISSION, 5'd0, 5'd0, 32'hFFFF_FFFF, 1'b1);
      send_item(hsfp_pkg::FUNC_EMISSION, 5'd1, 5'd0, 32'h0003_0000, 1'b1);

      // Random part: each setting gets its share of emissions.
      for (int p = 0; p < 8; p++) begin
         set_registers(state_plan[p], norm_plan[p]);
         k = sb.states_in_use();
         load_tables(k);
         phase_end = (p + 1) * RANDOM_ITEMS / 8;
         do run_step(k); while (random_sent < phase_end);
      end

      drain();
      $display("Covered %0d request beats over 8 register settings and %0d steps,",
               items_sent, sb.steps_done);
      $display("checking %0d result beats with %0d field mismatches.",
               sb.beats_checked, sb.mismatches);
      if (sb.mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
